@@ rtl/urfc_pkg.sv @@
`default_nettype none

package urfc_pkg;

  // Ring geometry
  localparam int RING_DEPTH = 2048;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int CNT_W      = 6;
  localparam int CMP_W      = (PTR_W + 1 > CNT_W) ? PTR_W + 1 : CNT_W;

  // Flow-control characters and limits
  localparam logic [7:0] XON_CODE      = 8'h11;
  localparam logic [7:0] XOFF_CODE     = 8'h13;
  localparam logic [7:0] LINE_ERR_MASK = 8'h1E;
  localparam logic [4:0] OVERFLOW_FLAG = 5'h01;
  localparam int         ROOM_MARGIN   = 12;
  localparam int         MAX_READ      = 61;

  typedef enum logic [1:0] {
    REQ_RX_BYTE     = 2'd0,
    REQ_LINE_STATUS = 2'd1,
    REQ_READ        = 2'd2,
    REQ_UNUSED      = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_HW   = 2'd1,
    MODE_SW   = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    KIND_XOFF     = 3'd0,
    KIND_DTR_LOW  = 3'd1,
    KIND_XON      = 3'd2,
    KIND_DTR_HIGH = 3'd3,
    KIND_DATA     = 3'd4,
    KIND_DONE     = 3'd5
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROC,
    ST_NEAR_FULL,
    ST_ROOM,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_EMIT_RD,
    ST_EMIT_OUT,
    ST_DONE
  } state_e;

  // One input item
  typedef struct packed {
    req_e       req_type;
    logic [7:0] rx_byte;
    logic [7:0] line_status;
    logic [5:0] max_len;
    logic [7:0] term_char;
  } item_t;

  // One result pushed from the sequencer into the output register
  typedef struct packed {
    logic             valid;
    kind_e            kind;
    logic [7:0]       data;
    logic             last;
    logic [CNT_W-1:0] count;
    logic [4:0]       errs;
  } result_t;

  // Ring pointer advance with wrap at the ring depth.
  function automatic logic [PTR_W-1:0] next_ptr(logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    n = (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    return n;
  endfunction

endpackage

`default_nettype wire

@@ rtl/uart_rx_ring_flow_control.sv @@
// Channel   Dir  Ports                 Fields (low bit up)
// --------  ---  --------------------  -----------------------------------------------
// s_axis    in   tdata[31:0], tuser    tdata: rx_byte, line_status, max_len, term_char
//                                      tuser: req_type
// m_axis    out  tdata[23:0], tuser,   tdata: data_byte, byte_count, error_flags
//                tlast                 tuser: result_kind; tlast: last
// cfg       in   cfg_we_i, cfg_wdata_i flow_mode
//
// A byte, a line-status event or an unused request is handled in ST_PROC; a byte that
// fills the ring adds ST_NEAR_FULL for its flow result. A read adds ST_ROOM for a flow
// result, ST_SCAN_RD and ST_SCAN_CMP per byte searched for the end character and
// ST_EMIT_RD and ST_EMIT_OUT per byte returned, set by the single read port of the ring
// memory, then ST_DONE, alone on an empty ring. Reset clears pointers and error status,
// but not the ring memory. A stalled result holds the sequencer in place until taken.
`default_nettype none

module uart_rx_ring_flow_control (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // rx_byte, line_status, max_len, term_char
  input  wire logic [1:0]  s_axis_tuser,  // req_type
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // data_byte, byte_count, error_flags
  output logic [2:0]       m_axis_tuser,  // result_kind
  output logic             m_axis_tlast,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_wdata_i
);
  import urfc_pkg::*;

  item_t            item;
  result_t          res_push;
  result_t          res_out;
  logic             slot_free;
  logic             mem_we;
  logic [PTR_W-1:0] mem_waddr;
  logic [7:0]       mem_wdata;
  logic             mem_re;
  logic [PTR_W-1:0] mem_raddr;
  logic [7:0]       mem_rdata;

  // Unpack the input item.
  assign item.req_type    = req_e'(s_axis_tuser);
  assign item.rx_byte     = s_axis_tdata[7:0];
  assign item.line_status = s_axis_tdata[15:8];
  assign item.max_len     = s_axis_tdata[21:16];
  assign item.term_char   = s_axis_tdata[29:22];

  urfc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .item_i      (item),
    .slot_free_i (slot_free),
    .res_o       (res_push),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  urfc_ram #(
    .DEPTH (RING_DEPTH),
    .WIDTH (8)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  urfc_out_reg u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .res_i         (res_push),
    .slot_free_o   (slot_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .res_o         (res_out)
  );

  // Pack the result item.
  assign m_axis_tdata = {5'b0, res_out.errs, res_out.count, res_out.data};
  assign m_axis_tuser = res_out.kind;
  assign m_axis_tlast = res_out.last;

endmodule

`default_nettype wire

@@ rtl/urfc_ram.sv @@
`default_nettype none

module urfc_ram #(
  parameter int DEPTH  = 2048,
  parameter int WIDTH  = 8,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/urfc_out_reg.sv @@
`default_nettype none

module urfc_out_reg (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire urfc_pkg::result_t res_i,
  output logic                  slot_free_o,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output urfc_pkg::result_t     res_o
);
  import urfc_pkg::*;

  logic    valid_q;
  result_t res_q;

  // The slot can take a new result when empty or being drained this cycle.
  assign slot_free_o = !valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_i.valid) begin
      valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      valid_q <= 1'b0;
    end
  end

  // Payload is loaded only together with valid.
  always_ff @(posedge clk_i) begin
    if (res_i.valid) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign res_o         = res_q;

endmodule

`default_nettype wire

@@ rtl/urfc_ctrl.sv @@
`default_nettype none

module urfc_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [1:0]                    cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire urfc_pkg::item_t               item_i,
  input  wire logic                          slot_free_i,
  output urfc_pkg::result_t                  res_o,
  output logic                               mem_we_o,
  output logic [urfc_pkg::PTR_W-1:0]         mem_waddr_o,
  output logic [7:0]                         mem_wdata_o,
  output logic                               mem_re_o,
  output logic [urfc_pkg::PTR_W-1:0]         mem_raddr_o,
  input  wire logic [7:0]                    mem_rdata_i
);
  import urfc_pkg::*;

  state_e           state_q, state_d;
  item_t            item_q;
  logic [1:0]       flow_mode_q;
  logic [PTR_W-1:0] wp_q, wp_d;
  logic [PTR_W-1:0] rp_q, rp_d;
  logic [PTR_W-1:0] scan_addr_q, scan_addr_d;
  logic [4:0]       err_q, err_d;
  logic [4:0]       errs_q, errs_d;
  logic [CNT_W-1:0] limit_q, limit_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] idx_q, idx_d;

  logic [PTR_W-1:0] nwp;
  logic [PTR_W:0]   avail;
  logic             room;
  logic [CNT_W-1:0] lim0;
  logic [CNT_W-1:0] lim1;
  logic [CNT_W-1:0] limit_c;
  logic             flow_on;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flow_mode_q <= MODE_NONE;
    end else if (cfg_we_i) begin
      flow_mode_q <= cfg_wdata_i;
    end
  end

  // Input item is captured when accepted.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  // Ring occupancy and read limit for a read request.
  always_comb begin
    nwp = next_ptr(wp_q);
    if (wp_q >= rp_q) begin
      avail = {1'b0, wp_q} - {1'b0, rp_q};
    end else begin
      avail = {1'b0, wp_q} + (PTR_W + 1)'(RING_DEPTH) - {1'b0, rp_q};
    end
    room    = avail <= (PTR_W + 1)'(RING_DEPTH - ROOM_MARGIN);
    lim0    = (item_q.max_len == '0) ? '0 : item_q.max_len - 1'b1;
    lim1    = (lim0 > CNT_W'(MAX_READ)) ? CNT_W'(MAX_READ) : lim0;
    limit_c = (CMP_W'(avail) < CMP_W'(lim1)) ? CNT_W'(avail) : lim1;
    flow_on = (flow_mode_q == MODE_SW) || (flow_mode_q == MODE_HW);
  end

  // Sequencer: next state, ring access and result push.
  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    rp_d        = rp_q;
    scan_addr_d = scan_addr_q;
    err_d       = err_q;
    errs_d      = errs_q;
    limit_d     = limit_q;
    count_d     = count_q;
    idx_d       = idx_q;
    res_o       = '0;
    mem_we_o    = 1'b0;
    mem_waddr_o = wp_q;
    mem_wdata_o = item_q.rx_byte;
    mem_re_o    = 1'b0;
    mem_raddr_o = rp_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_PROC;
        end
      end

      ST_PROC: begin
        state_d = ST_IDLE;
        case (item_q.req_type)
          REQ_RX_BYTE: begin
            // XON and XOFF are consumed here and not stored.
            if (item_q.rx_byte != XON_CODE && item_q.rx_byte != XOFF_CODE) begin
              mem_we_o = 1'b1;
              wp_d     = nwp;
              if (next_ptr(nwp) == rp_q) begin
                state_d = ST_NEAR_FULL;
              end
              // Overflow: the oldest byte is dropped.
              if (nwp == rp_q) begin
                err_d = OVERFLOW_FLAG;
                rp_d  = next_ptr(rp_q);
              end
            end
          end
          REQ_LINE_STATUS: begin
            err_d = 5'(item_q.line_status & LINE_ERR_MASK);
          end
          REQ_READ: begin
            errs_d      = err_q;
            err_d       = '0;
            limit_d     = limit_c;
            count_d     = '0;
            idx_d       = '0;
            scan_addr_d = rp_q;
            if (wp_q == rp_q) begin
              state_d = ST_DONE;
            end else begin
              if (item_q.term_char == '0) begin
                count_d = limit_c;
              end
              if (room && flow_on) begin
                state_d = ST_ROOM;
              end else if (item_q.term_char == '0) begin
                state_d = ST_EMIT_RD;
              end else begin
                state_d = ST_SCAN_RD;
              end
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end

      ST_NEAR_FULL: begin
        if (slot_free_i) begin
          res_o.valid = 1'b1;
          res_o.kind  = (flow_mode_q == MODE_SW) ? KIND_XOFF : KIND_DTR_LOW;
          res_o.last  = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      ST_ROOM: begin
        if (slot_free_i) begin
          res_o.valid = 1'b1;
          res_o.kind  = (flow_mode_q == MODE_SW) ? KIND_XON : KIND_DTR_HIGH;
          state_d     = (item_q.term_char == '0) ? ST_EMIT_RD : ST_SCAN_RD;
        end
      end

      // Search for the end character before anything is consumed.
      ST_SCAN_RD: begin
        mem_raddr_o = scan_addr_q;
        if (idx_q == limit_q) begin
          count_d = '0;
          state_d = ST_DONE;
        end else begin
          mem_re_o = 1'b1;
          state_d  = ST_SCAN_CMP;
        end
      end

      ST_SCAN_CMP: begin
        if (mem_rdata_i == item_q.term_char) begin
          count_d = idx_q + 1'b1;
          idx_d   = '0;
          state_d = ST_EMIT_RD;
        end else begin
          idx_d       = idx_q + 1'b1;
          scan_addr_d = next_ptr(scan_addr_q);
          state_d     = ST_SCAN_RD;
        end
      end

      // Return the bytes, advancing the read pointer one byte at a time.
      ST_EMIT_RD: begin
        if (idx_q == count_q) begin
          state_d = ST_DONE;
        end else begin
          mem_re_o = 1'b1;
          state_d  = ST_EMIT_OUT;
        end
      end

      ST_EMIT_OUT: begin
        if (slot_free_i) begin
          res_o.valid = 1'b1;
          res_o.kind  = KIND_DATA;
          res_o.data  = mem_rdata_i;
          rp_d        = next_ptr(rp_q);
          idx_d       = idx_q + 1'b1;
          state_d     = ST_EMIT_RD;
        end
      end

      ST_DONE: begin
        if (slot_free_i) begin
          res_o.valid = 1'b1;
          res_o.kind  = KIND_DONE;
          res_o.last  = 1'b1;
          res_o.count = count_q;
          res_o.errs  = errs_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wp_q    <= '0;
      rp_q    <= '0;
      err_q   <= '0;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      err_q   <= err_d;
    end
  end

  // Working registers of a read request.
  always_ff @(posedge clk_i) begin
    scan_addr_q <= scan_addr_d;
    errs_q      <= errs_d;
    limit_q     <= limit_d;
    count_q     <= count_d;
    idx_q       <= idx_d;
  end

endmodule

`default_nettype wire

@@ rtl/urfc_sva_mon.sv @@
`default_nettype none

module urfc_sva_mon (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic [2:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);
  import urfc_pkg::*;

  // A read-done result always closes its item.
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_DONE) |-> m_axis_tlast)
    else $error("read done without tlast");

  // Data bytes are never the final result of a read.
  a_data_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_DATA) |-> !m_axis_tlast)
    else $error("data byte marked last");

  // Count and error fields are zero on everything but read done.
  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != KIND_DONE) |-> (m_axis_tdata[18:8] == '0))
    else $error("status fields set outside read done");

  // A read never returns more than the saturated limit.
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[13:8] <= 6'(MAX_READ)))
    else $error("byte count above limit");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output changed while stalled");

endmodule

bind uart_rx_ring_flow_control urfc_sva_mon u_sva_mon (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

@@ test/uart_rx_ring_flow_control_test.sv @@
`timescale 1ns / 100ps

module uart_rx_ring_flow_control_test;
  import urfc_pkg::*;

  localparam logic [1:0] MODE_UNUSED   = 2'd3;
  localparam int         IDLE_LIMIT    = 2000;
  localparam int         SETTLE_CYCLES = 16;
  localparam int         DRAIN_CYCLES  = 50;

  // One result item as seen on the output stream.
  typedef struct packed {
    kind_e            kind;
    logic [7:0]       data;
    logic             last;
    logic [CNT_W-1:0] count;
    logic [4:0]       errs;
  } uart_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic [31:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tready = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_wdata_i   = '0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [23:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  // Predicted state of the receive ring.
  logic [7:0]       ring_mem [RING_DEPTH];
  logic [PTR_W-1:0] wr_ptr      = '0;
  logic [PTR_W-1:0] rd_ptr      = '0;
  logic             tx_enabled  = 1'b1;
  logic [4:0]       err_status  = '0;
  logic [1:0]       flow_mode_q = MODE_NONE;

  uart_result_t pending_results[$];
  int           mismatch_count = 0;
  int           idle_cycles    = 0;
  int           send_gap_pct   = 9;
  int           sink_stall_pct = 72;

  // Text bytes that make end characters likely to be found.
  logic [7:0] text_bytes [6] = '{8'h0A, 8'h0D, 8'h2C, 8'h30, 8'h31, 8'h41};

  uart_rx_ring_flow_control u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // The result sink stalls at random.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Number of bytes waiting in the predicted ring.
  function automatic int ring_fill();
    logic [PTR_W-1:0] diff;
    diff = wr_ptr - rd_ptr;
    return int'(diff);
  endfunction

  function automatic void push_result(kind_e kind, logic [7:0] data, logic last,
                                      logic [CNT_W-1:0] count, logic [4:0] errs);
    uart_result_t r;
    r = '{kind: kind, data: data, last: last, count: count, errs: errs};
    pending_results.push_back(r);
  endfunction

  // Update the predicted ring for one accepted item and queue its results.
  function automatic void ring_predict(item_t it);
    logic [PTR_W-1:0] idx;
    logic [4:0]       errs_before;
    int               avail;
    int               limit;
    int               count;
    case (it.req_type)
      REQ_RX_BYTE: begin
        if (it.rx_byte == XON_CODE) begin
          tx_enabled = 1'b1;
        end else if (it.rx_byte == XOFF_CODE) begin
          tx_enabled = 1'b0;
        end else begin
          ring_mem[wr_ptr] = it.rx_byte;
          wr_ptr = wr_ptr + 1'b1;
          // Only one free slot left: ask the far end to pause.
          if (ring_fill() == RING_DEPTH - 1) begin
            push_result((flow_mode_q == MODE_SW) ? KIND_XOFF : KIND_DTR_LOW,
                        8'h00, 1'b1, '0, '0);
          end
          // The ring wrapped onto the oldest byte, which is dropped.
          if (wr_ptr == rd_ptr) begin
            err_status = OVERFLOW_FLAG;
            rd_ptr = rd_ptr + 1'b1;
          end
        end
      end
      REQ_LINE_STATUS: begin
        err_status = it.line_status[4:0] & LINE_ERR_MASK[4:0];
      end
      REQ_READ: begin
        errs_before = err_status;
        err_status = '0;
        count = 0;
        avail = ring_fill();
        if (avail != 0) begin
          limit = (it.max_len == '0) ? 0 : int'(it.max_len) - 1;
          if (limit > MAX_READ) limit = MAX_READ;
          // Room has freed up, so the far end may resume.
          if (avail <= RING_DEPTH - ROOM_MARGIN) begin
            if (flow_mode_q == MODE_SW) begin
              push_result(KIND_XON, 8'h00, 1'b0, '0, '0);
            end else if (flow_mode_q == MODE_HW) begin
              push_result(KIND_DTR_HIGH, 8'h00, 1'b0, '0, '0);
            end
          end
          if (limit > avail) limit = avail;
          // A read with an end character takes nothing unless it is found.
          if (it.term_char == 8'h00) begin
            count = limit;
          end else begin
            for (int i = 0; i < limit && count == 0; i++) begin
              idx = rd_ptr + PTR_W'(i);
              if (ring_mem[idx] == it.term_char) count = i + 1;
            end
          end
          for (int i = 0; i < count; i++) begin
            idx = rd_ptr + PTR_W'(i);
            push_result(KIND_DATA, ring_mem[idx], 1'b0, '0, '0);
          end
          rd_ptr = rd_ptr + PTR_W'(count);
        end
        push_result(KIND_DONE, 8'h00, 1'b1, CNT_W'(count), errs_before);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic string fmt_result(uart_result_t r);
    return $sformatf("kind %0d data %02h last %0b count %0d errors %02h",
                     r.kind, r.data, r.last, r.count, r.errs);
  endfunction

  function automatic void note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch: %s", msg);
  endfunction

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk_i) begin : check_results
    uart_result_t want;
    uart_result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind  = kind_e'(m_axis_tuser);
      got.data  = m_axis_tdata[7:0];
      got.count = m_axis_tdata[13:8];
      got.errs  = m_axis_tdata[18:14];
      got.last  = m_axis_tlast;
      if (pending_results.size() == 0) begin
        note_mismatch({"expected nothing, got ", fmt_result(got)});
      end else begin
        want = pending_results.pop_front();
        if (got != want) begin
          note_mismatch({"expected ", fmt_result(want), ", got ", fmt_result(got)});
        end
      end
    end
  end

  // End the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Present one item, wait until it is taken, then predict its results.
  task automatic send_item(req_e rt, logic [7:0] rx, logic [7:0] ls, logic [5:0] ml,
                           logic [7:0] ec);
    item_t it;
    it = '{req_type: rt, rx_byte: rx, line_status: ls, max_len: ml, term_char: ec};
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= rt;
    s_axis_tdata  <= {2'b00, ec, ml, ls, rx};
    do @(posedge clk_i); while (!s_axis_tready);
    ring_predict(it);
  endtask

  task automatic send_byte(logic [7:0] b);
    send_item(REQ_RX_BYTE, b, 8'($urandom_range(255)), 6'($urandom_range(63)),
              8'($urandom_range(255)));
  endtask

  task automatic send_status(logic [7:0] ls);
    send_item(REQ_LINE_STATUS, 8'($urandom_range(255)), ls, 6'($urandom_range(63)),
              8'($urandom_range(255)));
  endtask

  task automatic send_read(logic [5:0] ml, logic [7:0] ec);
    send_item(REQ_READ, 8'($urandom_range(255)), 8'($urandom_range(255)), ml, ec);
  endtask

  function automatic logic [7:0] pick_text_byte();
    return text_bytes[$urandom_range(5)];
  endfunction

  // Wait until every predicted result is out and the block has gone quiet.
  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_mode(logic [1:0] mode);
    settle_block();
    cfg_wdata_i <= mode;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    flow_mode_q = mode;
    cfg_we_i    <= 1'b0;
  endtask

  // Field extremes, control characters, error bits and the read corner cases.
  task automatic test_directed_requests();
    send_read(6'd63, 8'h00);
    send_status(8'hFF);
    send_read(6'd10, 8'h00);
    send_status(8'hE1);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(XON_CODE);
    send_byte(XOFF_CODE);
    send_byte(8'h41);
    send_byte(8'h0A);
    send_byte(8'h42);
    send_item(REQ_UNUSED, 8'hFF, 8'hFF, 6'h3F, 8'hFF);
    send_read(6'd0, 8'h00);
    send_read(6'd1, 8'h00);
    send_read(6'd63, 8'h99);
    send_read(6'd63, 8'h0A);
    send_read(6'd2, 8'h00);
  endtask

  // A read with data waiting, once per flow mode.
  task automatic test_flow_modes();
    logic [1:0] modes [4];
    modes = '{MODE_HW, MODE_SW, MODE_UNUSED, MODE_NONE};
    foreach (modes[m]) begin
      write_mode(modes[m]);
      send_byte(pick_text_byte());
      send_read(6'd63, 8'h00);
    end
  endtask

  // Mostly received bytes and reads with random content; some noise.
  task automatic test_random(int n_items);
    int         counted;
    int         pick;
    logic [7:0] rx;
    logic [7:0] ec;
    counted = 0;
    while (counted < n_items) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        pick = $urandom_range(99);
        if (pick < 65) rx = pick_text_byte();
        else if (pick < 72) rx = pick[0] ? XON_CODE : XOFF_CODE;
        else rx = 8'($urandom_range(255));
        send_byte(rx);
        counted++;
      end else if (pick < 82) begin
        pick = $urandom_range(99);
        if (pick < 40) ec = 8'h00;
        else if (pick < 85) ec = pick_text_byte();
        else ec = 8'($urandom_range(255));
        send_read(6'($urandom_range(63)), ec);
        counted++;
      end else if (pick < 96) begin
        send_status(8'($urandom_range(255)));
        counted++;
      end else begin
        send_item(REQ_UNUSED, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  6'($urandom_range(63)), 8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_requests();
    test_flow_modes();
    write_mode(MODE_SW);
    test_random(150);

    send_gap_pct   = 72;
    sink_stall_pct = 9;
    write_mode(MODE_HW);
    test_random(155);

    send_gap_pct   = 0;
    sink_stall_pct = 0;
    write_mode(MODE_NONE);
    test_random(155);

    settle_block();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/urfc_pkg.sv
rtl/urfc_ram.sv
rtl/urfc_out_reg.sv
rtl/urfc_ctrl.sv
rtl/uart_rx_ring_flow_control.sv
rtl/urfc_sva_mon.sv
test/uart_rx_ring_flow_control_test.sv
